// File: rtl/ccs_pkg.sv
// Shared types, constants and the triangle sign table for the contour cell block.
`default_nettype none
package ccs_pkg;

  localparam int COORD_W  = 32;            // Q16.16 coordinate and value width
  localparam int OFS_W    = COORD_W + 1;   // value minus level, exact
  localparam int H_W      = OFS_W + 2;     // offset value scaled by four
  localparam int MAG_W    = H_W;           // magnitude of a scaled value
  localparam int DEN_W    = MAG_W + 1;     // sum of two magnitudes
  localparam int D_W      = COORD_W + 1;   // coordinate difference
  localparam int Q_W      = D_W;           // interpolation offset
  localparam int STEP_CNT = D_W;           // one step per bit of the difference
  localparam int CNT_W    = $clog2(STEP_CNT + 1);

  // Sign codes of a vertex value.
  localparam logic [1:0] SGN_NEG  = 2'd0;
  localparam logic [1:0] SGN_ZERO = 2'd1;
  localparam logic [1:0] SGN_POS  = 2'd2;

  // Segment kinds of one triangle (v1, centre, v3).
  localparam logic [3:0] CS_NONE  = 4'd0;
  localparam logic [3:0] CS_VV_12 = 4'd1;  // vertex 1 to vertex 2
  localparam logic [3:0] CS_VV_23 = 4'd2;
  localparam logic [3:0] CS_VV_31 = 4'd3;
  localparam logic [3:0] CS_VE_1  = 4'd4;  // vertex 1 to edge 2-3
  localparam logic [3:0] CS_VE_2  = 4'd5;
  localparam logic [3:0] CS_VE_3  = 4'd6;
  localparam logic [3:0] CS_EE_1  = 4'd7;  // edge 1-2 to edge 2-3
  localparam logic [3:0] CS_EE_2  = 4'd8;
  localparam logic [3:0] CS_EE_3  = 4'd9;

  // Indexed by sign code of v1 * 9 + sign code of v2 * 3 + sign code of v3.
  localparam logic [3:0] CASE_TAB [27] = '{
    4'd0, 4'd0, 4'd8,  4'd0, 4'd2, 4'd5,  4'd7, 4'd6, 4'd9,
    4'd0, 4'd3, 4'd4,  4'd1, 4'd0, 4'd1,  4'd4, 4'd3, 4'd0,
    4'd9, 4'd6, 4'd7,  4'd5, 4'd2, 4'd0,  4'd8, 4'd0, 4'd0
  };

  // One segment endpoint: c1 + sign(d) * floor(|d| * num / den).
  typedef struct packed {
    logic [COORD_W-1:0] c1x;
    logic [COORD_W-1:0] c1y;
    logic [D_W-1:0]     dx;
    logic [D_W-1:0]     dy;
    logic [MAG_W-1:0]   num;
    logic [DEN_W-1:0]   den;
  } ep_t;

  typedef struct packed {
    ep_t  p_start;
    ep_t  p_end;
    logic has_seg;
    logic last;
  } job_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_RUN,
    BK_DONE
  } bk_state_t;

endpackage
`default_nettype wire

// File: rtl/ccs_ifs.sv
// Channel interfaces of the contour cell block: cell input, segment output, level write.
`default_nettype none
interface ccs_in_if import ccs_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] value_a;
  logic [COORD_W-1:0] value_b;
  logic [COORD_W-1:0] value_c;
  logic [COORD_W-1:0] value_d;
  logic [COORD_W-1:0] corner_a_x;
  logic [COORD_W-1:0] corner_a_y;
  logic [COORD_W-1:0] corner_b_x;
  logic [COORD_W-1:0] corner_b_y;
  logic [COORD_W-1:0] corner_c_x;
  logic [COORD_W-1:0] corner_c_y;
  logic [COORD_W-1:0] corner_d_x;
  logic [COORD_W-1:0] corner_d_y;
  modport source (output valid, value_a, value_b, value_c, value_d,
                  corner_a_x, corner_a_y, corner_b_x, corner_b_y,
                  corner_c_x, corner_c_y, corner_d_x, corner_d_y,
                  input ready);
  modport sink   (input valid, value_a, value_b, value_c, value_d,
                  corner_a_x, corner_a_y, corner_b_x, corner_b_y,
                  corner_c_x, corner_c_y, corner_d_x, corner_d_y,
                  output ready);
endinterface

interface ccs_out_if import ccs_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] start_x;
  logic [COORD_W-1:0] start_y;
  logic [COORD_W-1:0] end_x;
  logic [COORD_W-1:0] end_y;
  logic               has_segment;
  logic               last_segment;
  modport source (output valid, start_x, start_y, end_x, end_y, has_segment,
                  last_segment, input ready);
  modport sink   (input valid, start_x, start_y, end_x, end_y, has_segment,
                  last_segment, output ready);
endinterface

interface ccs_cfg_if import ccs_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] contour_level;
  modport source (output valid, contour_level, input ready);
  modport sink   (input valid, contour_level, output ready);
endinterface
`default_nettype wire

// File: rtl/ccs_front.sv
// Front end: holds the level, registers a cell, classifies its four triangles, queues jobs.
`default_nettype none
module ccs_front import ccs_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  ccs_in_if.sink     in_bus,
  ccs_cfg_if.sink    cfg_bus,
  input  wire logic  q_full,
  output logic       push,
  output job_t       push_job
);

  logic [COORD_W-1:0]   level_r;
  logic signed [H_W-1:0] h_r [5];
  logic [COORD_W-1:0]   x_r [5];
  logic [COORD_W-1:0]   y_r [5];
  logic [3:0]           cs_r [4];
  logic                 busy_r;
  logic [1:0]           tri_r;

  logic signed [H_W-1:0] h_c [5];
  logic [COORD_W-1:0]   x_c [5];
  logic [COORD_W-1:0]   y_c [5];
  logic [1:0]           sg_c [5];
  logic [3:0]           cs_c [4];
  logic [COORD_W-1:0]   vin [4];
  logic                 accept;
  logic                 advance;
  logic                 need;
  logic                 any_nz;
  logic                 later_nz;

  assign cfg_bus.ready = 1'b1;

  function automatic logic [1:0] sgn_code(input logic signed [H_W-1:0] v);
    if (v < 0) return SGN_NEG;
    else if (v == 0) return SGN_ZERO;
    else return SGN_POS;
  endfunction

  function automatic logic [MAG_W-1:0] mag(input logic signed [H_W-1:0] v);
    return (v < 0) ? MAG_W'(-v) : MAG_W'(v);
  endfunction

  // Endpoint from vertex a toward vertex b; a plain vertex when there is no strict sign change.
  function automatic ep_t make_ep(input logic signed [H_W-1:0] ha,
                                  input logic signed [H_W-1:0] hb,
                                  input logic [COORD_W-1:0] xa, input logic [COORD_W-1:0] xb,
                                  input logic [COORD_W-1:0] ya, input logic [COORD_W-1:0] yb,
                                  input logic is_edge);
    ep_t e;
    e.c1x = xa;
    e.c1y = ya;
    if (is_edge && ((ha < 0 && hb > 0) || (ha > 0 && hb < 0))) begin
      e.dx  = {xb[COORD_W-1], xb} - {xa[COORD_W-1], xa};
      e.dy  = {yb[COORD_W-1], yb} - {ya[COORD_W-1], ya};
      e.num = mag(ha);
      e.den = {1'b0, mag(ha)} + {1'b0, mag(hb)};
    end else begin
      e.dx  = '0;
      e.dy  = '0;
      e.num = '0;
      e.den = DEN_W'(1);
    end
    return e;
  endfunction

  // Classification of the incoming cell.
  always_comb begin
    logic signed [OFS_W-1:0] o [4];
    logic signed [OFS_W-1:0] lvl;
    logic [COORD_W:0] sx;
    logic [COORD_W:0] sy;
    vin[0] = in_bus.value_a;
    vin[1] = in_bus.value_b;
    vin[2] = in_bus.value_c;
    vin[3] = in_bus.value_d;
    lvl = $signed({level_r[COORD_W-1], level_r});
    for (int m = 0; m < 4; m++) begin
      o[m] = $signed({vin[m][COORD_W-1], vin[m]}) - lvl;
      h_c[m+1] = $signed({o[m], 2'b00});
    end
    h_c[0] = H_W'(o[0]) + H_W'(o[1]) + H_W'(o[2]) + H_W'(o[3]);
    x_c[1] = in_bus.corner_a_x;  y_c[1] = in_bus.corner_a_y;
    x_c[2] = in_bus.corner_b_x;  y_c[2] = in_bus.corner_b_y;
    x_c[3] = in_bus.corner_c_x;  y_c[3] = in_bus.corner_c_y;
    x_c[4] = in_bus.corner_d_x;  y_c[4] = in_bus.corner_d_y;
    sx = {x_c[1][COORD_W-1], x_c[1]} + {x_c[2][COORD_W-1], x_c[2]};
    sy = {y_c[1][COORD_W-1], y_c[1]} + {y_c[4][COORD_W-1], y_c[4]};
    x_c[0] = sx[COORD_W:1];
    y_c[0] = sy[COORD_W:1];
    for (int m = 0; m < 5; m++) sg_c[m] = sgn_code(h_c[m]);
    for (int t = 0; t < 4; t++) begin
      cs_c[t] = CASE_TAB[5'(sg_c[t+1]) * 5'd9 + 5'(sg_c[0]) * 5'd3
                         + 5'(sg_c[(t == 3) ? 1 : t + 2])];
    end
  end

  // Job for the triangle under the walk.
  always_comb begin
    logic [2:0] v1;
    logic [2:0] v3;
    logic [2:0] pa, pb, qa, qb;
    logic [3:0] cs;
    v1 = 3'(tri_r) + 3'd1;
    v3 = (tri_r == 2'd3) ? 3'd1 : 3'(tri_r) + 3'd2;
    cs = cs_r[tri_r];
    pa = v1; pb = v1; qa = 3'd0; qb = 3'd0;
    case (cs)
      CS_VV_12: begin pa = v1;   pb = v1;   qa = 3'd0; qb = 3'd0; end
      CS_VV_23: begin pa = 3'd0; pb = 3'd0; qa = v3;   qb = v3;   end
      CS_VV_31: begin pa = v3;   pb = v3;   qa = v1;   qb = v1;   end
      CS_VE_1:  begin pa = v1;   pb = v1;   qa = 3'd0; qb = v3;   end
      CS_VE_2:  begin pa = 3'd0; pb = 3'd0; qa = v3;   qb = v1;   end
      CS_VE_3:  begin pa = v3;   pb = v3;   qa = v1;   qb = 3'd0; end
      CS_EE_1:  begin pa = v1;   pb = 3'd0; qa = 3'd0; qb = v3;   end
      CS_EE_2:  begin pa = 3'd0; pb = v3;   qa = v3;   qb = v1;   end
      CS_EE_3:  begin pa = v3;   pb = v1;   qa = v1;   qb = 3'd0; end
      default:  begin pa = v1;   pb = v1;   qa = v1;   qb = v1;   end
    endcase

    any_nz = 1'b0;
    later_nz = 1'b0;
    for (int t = 0; t < 4; t++) begin
      if (cs_r[t] != CS_NONE) begin
        any_nz = 1'b1;
        if (2'(t) > tri_r) later_nz = 1'b1;
      end
    end

    push_job.p_start = make_ep(h_r[pa], h_r[pb], x_r[pa], x_r[pb], y_r[pa], y_r[pb],
                               pa != pb);
    push_job.p_end   = make_ep(h_r[qa], h_r[qb], x_r[qa], x_r[qb], y_r[qa], y_r[qb],
                               qa != qb);
    push_job.has_seg = any_nz;
    push_job.last    = !later_nz;
    if (!any_nz) begin
      push_job.p_start = make_ep('0, '0, '0, '0, '0, '0, 1'b0);
      push_job.p_end   = push_job.p_start;
    end

    need    = (cs != CS_NONE) || (!any_nz && tri_r == 2'd0);
    advance = busy_r && !(need && q_full);
    push    = busy_r && need && !q_full;
  end

  assign in_bus.ready = !busy_r || (advance && tri_r == 2'd3);
  assign accept       = in_bus.valid && in_bus.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r <= '0;
      busy_r  <= 1'b0;
      tri_r   <= '0;
    end else begin
      if (cfg_bus.valid) level_r <= cfg_bus.contour_level;
      if (accept) begin
        busy_r <= 1'b1;
        tri_r  <= '0;
      end else if (advance) begin
        tri_r <= tri_r + 2'd1;
        if (tri_r == 2'd3) busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int m = 0; m < 5; m++) begin
        h_r[m] <= h_c[m];
        x_r[m] <= x_c[m];
        y_r[m] <= y_c[m];
      end
      for (int t = 0; t < 4; t++) cs_r[t] <= cs_c[t];
    end
  end

endmodule
`default_nettype wire

// File: rtl/ccs_fifo.sv
// Short job queue between the front end and the interpolation back end.
`default_nettype none
module ccs_fifo import ccs_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  job_t      push_job,
  input  wire logic pop,
  output logic      full,
  output logic      empty,
  output job_t      head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W2 = $clog2(DEPTH + 1);

  job_t              mem [DEPTH];
  logic [PTR_W-1:0]  wr_r;
  logic [PTR_W-1:0]  rd_r;
  logic [CNT_W2-1:0] cnt_r;

  assign full  = (cnt_r == CNT_W2'(DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem[rd_r];

  always_ff @(posedge clk) begin
    if (push) mem[wr_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= (wr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_r + PTR_W'(1);
      if (pop)  rd_r <= (rd_r == PTR_W'(DEPTH - 1)) ? '0 : rd_r + PTR_W'(1);
      if (push && !pop) cnt_r <= cnt_r + CNT_W2'(1);
      else if (pop && !push) cnt_r <= cnt_r - CNT_W2'(1);
    end
  end

endmodule
`default_nettype wire

// File: rtl/ccs_muldiv.sv
// Bit-serial floor(a * b / den) with b below den, one bit of a per cycle.
`default_nettype none
module ccs_muldiv import ccs_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [D_W-1:0]   a_in,
  input  wire logic [MAG_W-1:0] b_in,
  input  wire logic [DEN_W-1:0] den_in,
  output logic                  busy,
  output logic [Q_W-1:0]        q
);

  logic                 busy_r;
  logic [CNT_W-1:0]     cnt_r;
  logic [D_W-1:0]       a_r;
  logic [MAG_W-1:0]     b_r;
  logic [DEN_W-1:0]     den_r;
  logic [DEN_W-1:0]     rem_r;
  logic [Q_W-1:0]       q_r;
  logic [DEN_W-1:0]     rem_nxt;
  logic [Q_W-1:0]       q_nxt;

  // Invariant: prefix(a) * b = q * den + rem, rem < den; the new sum stays below 3 * den.
  always_comb begin
    logic [DEN_W+1:0] rs;
    logic [DEN_W+1:0] d1;
    logic [DEN_W+1:0] d2;
    rs = {1'b0, rem_r, 1'b0} + (a_r[D_W-1] ? (DEN_W+2)'(b_r) : '0);
    d1 = (DEN_W+2)'(den_r);
    d2 = {1'b0, den_r, 1'b0};
    if (rs >= d2) begin
      rem_nxt = DEN_W'(rs - d2);
      q_nxt   = {q_r[Q_W-2:0], 1'b0} + Q_W'(2);
    end else if (rs >= d1) begin
      rem_nxt = DEN_W'(rs - d1);
      q_nxt   = {q_r[Q_W-2:0], 1'b0} + Q_W'(1);
    end else begin
      rem_nxt = DEN_W'(rs);
      q_nxt   = {q_r[Q_W-2:0], 1'b0};
    end
  end

  assign busy = busy_r;
  assign q    = q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(STEP_CNT);
    end else if (busy_r) begin
      cnt_r <= cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= a_in;
      b_r   <= b_in;
      den_r <= den_in;
      rem_r <= '0;
      q_r   <= '0;
    end else if (busy_r) begin
      a_r   <= {a_r[D_W-2:0], 1'b0};
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
    end
  end

endmodule
`default_nettype wire

// File: rtl/ccs_back.sv
// Back end: takes a job, interpolates both endpoints in four serial units, holds the result.
`default_nettype none
module ccs_back import ccs_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic q_empty,
  input  job_t      head,
  output logic      pop,
  ccs_out_if.source out_bus
);

  bk_state_t          st_r, st_nxt;
  job_t               job_r;
  logic               out_valid_r;
  logic [COORD_W-1:0] sx_r, sy_r, ex_r, ey_r;
  logic               has_r, last_r;
  logic               start;
  logic               load_out;
  logic [3:0]         busy;
  logic [Q_W-1:0]     qv [4];

  function automatic logic [D_W-1:0] dmag(input logic [D_W-1:0] d);
    return d[D_W-1] ? D_W'(-d) : d;
  endfunction

  function automatic logic [COORD_W-1:0] place(input logic [COORD_W-1:0] c,
                                               input logic [D_W-1:0] d,
                                               input logic [Q_W-1:0] qq);
    logic [COORD_W+1:0] s;
    logic [COORD_W+1:0] off;
    off = {1'b0, qq};
    s = {{2{c[COORD_W-1]}}, c} + (d[D_W-1] ? -off : off);
    return s[COORD_W-1:0];
  endfunction

  ccs_muldiv u_sx (.clk, .rst_n, .start, .a_in(dmag(head.p_start.dx)),
    .b_in(head.p_start.num), .den_in(head.p_start.den), .busy(busy[0]), .q(qv[0]));
  ccs_muldiv u_sy (.clk, .rst_n, .start, .a_in(dmag(head.p_start.dy)),
    .b_in(head.p_start.num), .den_in(head.p_start.den), .busy(busy[1]), .q(qv[1]));
  ccs_muldiv u_ex (.clk, .rst_n, .start, .a_in(dmag(head.p_end.dx)),
    .b_in(head.p_end.num), .den_in(head.p_end.den), .busy(busy[2]), .q(qv[2]));
  ccs_muldiv u_ey (.clk, .rst_n, .start, .a_in(dmag(head.p_end.dy)),
    .b_in(head.p_end.num), .den_in(head.p_end.den), .busy(busy[3]), .q(qv[3]));

  always_comb begin
    st_nxt   = st_r;
    pop      = 1'b0;
    start    = 1'b0;
    load_out = 1'b0;
    case (st_r)
      BK_IDLE: begin
        if (!q_empty) begin
          pop    = 1'b1;
          start  = 1'b1;
          st_nxt = BK_RUN;
        end
      end
      BK_RUN: begin
        if (busy == 4'b0000) st_nxt = BK_DONE;
      end
      BK_DONE: begin
        if (!out_valid_r || out_bus.ready) begin
          load_out = 1'b1;
          st_nxt   = BK_IDLE;
        end
      end
      default: st_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (load_out) out_valid_r <= 1'b1;
      else if (out_bus.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) job_r <= head;
    if (load_out) begin
      sx_r   <= place(job_r.p_start.c1x, job_r.p_start.dx, qv[0]);
      sy_r   <= place(job_r.p_start.c1y, job_r.p_start.dy, qv[1]);
      ex_r   <= place(job_r.p_end.c1x, job_r.p_end.dx, qv[2]);
      ey_r   <= place(job_r.p_end.c1y, job_r.p_end.dy, qv[3]);
      has_r  <= job_r.has_seg;
      last_r <= job_r.last;
    end
  end

  assign out_bus.valid        = out_valid_r;
  assign out_bus.start_x      = sx_r;
  assign out_bus.start_y      = sy_r;
  assign out_bus.end_x        = ex_r;
  assign out_bus.end_y        = ey_r;
  assign out_bus.has_segment  = has_r;
  assign out_bus.last_segment = last_r;

endmodule
`default_nettype wire

// File: rtl/contour_cell_segments.sv
// Top level of the contour cell block: front end, job queue and interpolation back end.
//
// Use: one beat on in_bus carries a grid cell (four corner values, four corner
// coordinates, all signed Q16.16). The contour level is written through cfg_bus,
// which is always ready; write it only while the block is idle. Each cell yields
// one to four beats on out_bus, one per contour segment in triangle order, with
// last_segment set on the final beat. A cell without a segment yields a single
// beat with has_segment clear and zero coordinates.
// Timing: the front end registers a cell and walks its four triangles one per
// cycle while the job queue has room, and is ready for the next cell while it
// walks the last triangle. The back end handles one segment at a time: BK_IDLE
// pops the job and starts the bit-serial interpolation units (one bit of the
// coordinate difference per cycle), BK_RUN waits for them, and BK_DONE loads
// the output register. Sustained rate is set by the back end, which takes a new
// segment only after the last one has gone into the output register.
// Reset (rst_n low at a clock edge) empties the queue and output register and
// sets the level to zero. When the receiver stalls, the output beat is held,
// the back end waits, the queue fills and then in_bus.ready drops.
`default_nettype none
module contour_cell_segments import ccs_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  ccs_in_if.sink     in_bus,
  ccs_cfg_if.sink    cfg_bus,
  ccs_out_if.source  out_bus
);

  logic q_push;
  job_t q_push_job;
  logic q_pop;
  logic q_full;
  logic q_empty;
  job_t q_head;

  // Front end: level register, cell classification and the triangle walk.
  ccs_front u_front (
    .clk, .rst_n,
    .in_bus, .cfg_bus,
    .q_full,
    .push(q_push),
    .push_job(q_push_job)
  );

  // Queue of segment jobs so the front end keeps taking cells while
  // the back end is busy with interpolation.
  ccs_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk, .rst_n,
    .push(q_push),
    .push_job(q_push_job),
    .pop(q_pop),
    .full(q_full),
    .empty(q_empty),
    .head(q_head)
  );

  // Back end: endpoint interpolation and the output register.
  ccs_back u_back (
    .clk, .rst_n,
    .q_empty,
    .head(q_head),
    .pop(q_pop),
    .out_bus
  );

endmodule
`default_nettype wire
